FILE: design/kc_pkg.sv
package kc_pkg;

  // Default sizing
  localparam int MAX_RADIUS = 2;
  localparam int COEF_BITS  = 24;

  // Fixed field widths
  localparam int FRAC_BITS = 16;
  localparam int INDEX_W   = 5;
  localparam int OP_W      = 2;
  localparam int RADIUS_W  = 2;
  localparam int CFG_IDX_W = 1;
  localparam int ACC_W     = 64;

  // Input word operations
  typedef enum logic [OP_W-1:0] {
    OP_LOAD_FIRST  = 2'd0,
    OP_LOAD_SECOND = 2'd1,
    OP_COMPOSE     = 2'd2
  } op_e;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_RADIUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_RADIUS = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  // Control that follows one product term down the datapath
  typedef struct packed {
    logic valid;       // term present in this stage
    logic take;        // term contributes (else adds zero)
    logic first;       // first term of an output position
    logic last_term;   // last term of an output position
    logic last_pos;    // position is the final one of the grid
    logic copy;        // pass one stored coefficient through
    logic src_second;  // copy source is the second store
  } term_t;

endpackage

FILE: design/kernel_composition_core.sv
// Datapath: a compose word issues one product a cycle, while the output is not stalled, into one
//   shared multiplier. With R = max(ra, rb), N = (2*R+1)^2 * (2*rb+1)^2 terms (N = (2*R+1)^2
//   for a copy, where one radius is zero); each term passes the store read, product, accumulator
//   and output registers. Load words are taken back to back while idle; after a compose the next
//   word is taken only once the datapath has drained and its last output word has been taken.
// Reset (rst_ni, async, active low) clears radii, sequencer and valids, not the stores.
module kernel_composition_core #(
  parameter int MAX_RADIUS = kc_pkg::MAX_RADIUS,
  parameter int COEF_BITS  = kc_pkg::COEF_BITS,
  localparam int IN_DATA_W  = ((kc_pkg::INDEX_W + COEF_BITS + 7) / 8) * 8,
  localparam int OUT_DATA_W = ((COEF_BITS + 7) / 8) * 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // config write port
  input  logic                           cfg_we_i,
  input  logic [kc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kc_pkg::RADIUS_W-1:0]    cfg_data_i,
  // input stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [IN_DATA_W-1:0]           s_axis_tdata,   // index, coef_in
  input  logic [kc_pkg::OP_W-1:0]        s_axis_tuser,   // operation
  // output stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [OUT_DATA_W-1:0]          m_axis_tdata,   // coef_out
  output logic                           m_axis_tlast,
  output logic                           m_axis_tuser    // overflow
);

  localparam int SIDE   = 2 * MAX_RADIUS + 1;
  localparam int DEPTH  = SIDE * SIDE;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int CRD_W  = RAD_W + 2;
  localparam int PROD_W = 2 * COEF_BITS;
  localparam int ACC_W  = kc_pkg::ACC_W;

  localparam logic signed [ACC_W-1:0] ACC_MAX  = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN  = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (kc_pkg::FRAC_BITS - 1);

  // 64-bit add that clamps at the limits
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W-1:0] s;
    s = a + b;
    if ((a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1])) begin
      s = a[ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // ---------------------------------------------------------------
  // Input word fields
  logic [kc_pkg::INDEX_W-1:0] in_index;
  logic [COEF_BITS-1:0]       in_coef;
  logic                       in_acc;
  assign in_index = s_axis_tdata[kc_pkg::INDEX_W-1:0];
  assign in_coef  = s_axis_tdata[kc_pkg::INDEX_W +: COEF_BITS];
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------
  // Radius registers
  logic [kc_pkg::RADIUS_W-1:0] rad_first_q, rad_second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_first_q  <= '0;
      rad_second_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == kc_pkg::CFG_FIRST_RADIUS) begin
        rad_first_q <= cfg_data_i;
      end else begin
        rad_second_q <= cfg_data_i;
      end
    end
  end

  // Effective radii, clamped to the store size
  logic [RAD_W-1:0] ra, rb, rg;
  logic             copy_mode, src_second, no_kernel;
  logic signed [CRD_W-1:0] ra_s, rb_s, rg_s;

  always_comb begin
    ra = (32'(rad_first_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(rad_first_q);
    rb = (32'(rad_second_q) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : RAD_W'(rad_second_q);
    rg = (ra > rb) ? ra : rb;
    ra_s = CRD_W'(ra);
    rb_s = CRD_W'(rb);
    rg_s = CRD_W'(rg);
    copy_mode  = (ra == '0) || (rb == '0);
    src_second = (ra == '0);
    no_kernel  = (ra == '0) && (rb == '0);
  end

  // ---------------------------------------------------------------
  // Sequencer and loop counters
  kc_pkg::state_e state_q, state_d;
  logic signed [CRD_W-1:0] sx_q, sx_d, sy_q, sy_d, dx_q, dx_d, dy_q, dy_d;
  logic [ADDR_W-1:0]       bk_q, bk_d, pos_q, pos_d;
  logic                    adv;
  kc_pkg::term_t           issue, s1_q, s2_q, s3_q;

  // whole datapath moves when the output register is free or being taken
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state_q == kc_pkg::ST_IDLE);

  // Current term: grid position and offset into the second kernel
  logic signed [CRD_W-1:0] cx, cy;
  logic                    in_first;
  logic [ADDR_W-1:0]       a_row, a_col, a_side, a_addr;
  logic [2*ADDR_W-1:0]     a_lin;
  logic [ADDR_W-1:0]       rd_first_addr, rd_second_addr;

  always_comb begin
    cx = sx_q + dx_q;
    cy = sy_q + dy_q;
    in_first = (cx >= -ra_s) && (cx <= ra_s) && (cy >= -ra_s) && (cy <= ra_s);
    a_row  = ADDR_W'(cy + ra_s);
    a_col  = ADDR_W'(cx + ra_s);
    a_side = ADDR_W'({ra, 1'b1});
    a_lin  = (2*ADDR_W)'(a_row) * (2*ADDR_W)'(a_side) + (2*ADDR_W)'(a_col);
    a_addr = in_first ? a_lin[ADDR_W-1:0] : '0;
    rd_first_addr  = copy_mode ? pos_q : a_addr;
    rd_second_addr = copy_mode ? pos_q : bk_q;

    issue.valid      = 1'b1;
    issue.take       = copy_mode || in_first;
    issue.first      = copy_mode || ((dx_q == -rb_s) && (dy_q == -rb_s));
    issue.last_term  = copy_mode || ((dx_q == rb_s) && (dy_q == rb_s));
    issue.last_pos   = (sx_q == rg_s) && (sy_q == rg_s);
    issue.copy       = copy_mode;
    issue.src_second = src_second;
  end

  // Next state and counter stepping
  always_comb begin
    state_d = state_q;
    sx_d = sx_q;
    sy_d = sy_q;
    dx_d = dx_q;
    dy_d = dy_q;
    bk_d = bk_q;
    pos_d = pos_q;
    unique case (state_q)
      kc_pkg::ST_IDLE: begin
        if (in_acc && (s_axis_tuser == kc_pkg::OP_COMPOSE) && !no_kernel) begin
          state_d = kc_pkg::ST_RUN;
          sx_d  = -rg_s;
          sy_d  = -rg_s;
          dx_d  = -rb_s;
          dy_d  = -rb_s;
          bk_d  = '0;
          pos_d = '0;
        end
      end
      kc_pkg::ST_RUN: begin
        if (adv) begin
          if (issue.last_term && issue.last_pos) begin
            state_d = kc_pkg::ST_DRAIN;
          end
          if (!copy_mode && (dx_q != rb_s)) begin
            dx_d = dx_q + CRD_W'(1);
            bk_d = bk_q + ADDR_W'(1);
          end else if (!copy_mode && (dy_q != rb_s)) begin
            dx_d = -rb_s;
            dy_d = dy_q + CRD_W'(1);
            bk_d = bk_q + ADDR_W'(1);
          end else begin
            // move to the next output position
            dx_d  = -rb_s;
            dy_d  = -rb_s;
            bk_d  = '0;
            pos_d = pos_q + ADDR_W'(1);
            if (sx_q != rg_s) begin
              sx_d = sx_q + CRD_W'(1);
            end else begin
              sx_d = -rg_s;
              sy_d = sy_q + CRD_W'(1);
            end
          end
        end
      end
      kc_pkg::ST_DRAIN: begin
        if (!s1_q.valid && !s2_q.valid && !s3_q.valid && !m_axis_tvalid) begin
          state_d = kc_pkg::ST_IDLE;
        end
      end
      default: state_d = kc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kc_pkg::ST_IDLE;
      sx_q  <= '0;
      sy_q  <= '0;
      dx_q  <= '0;
      dy_q  <= '0;
      bk_q  <= '0;
      pos_q <= '0;
    end else begin
      state_q <= state_d;
      sx_q  <= sx_d;
      sy_q  <= sy_d;
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      bk_q  <= bk_d;
      pos_q <= pos_d;
    end
  end

  // ---------------------------------------------------------------
  // Coefficient stores: loaded while idle, read with registered data
  logic [COEF_BITS-1:0]        mem_first  [DEPTH];
  logic [COEF_BITS-1:0]        mem_second [DEPTH];
  logic signed [COEF_BITS-1:0] rd_first_q, rd_second_q;
  logic                        we_ok;
  logic [ADDR_W-1:0]           wr_addr;

  assign we_ok   = in_acc && (32'(in_index) < DEPTH);
  assign wr_addr = ADDR_W'(in_index);

  always_ff @(posedge clk_i) begin
    if (we_ok && (s_axis_tuser == kc_pkg::OP_LOAD_FIRST)) begin
      mem_first[wr_addr] <= in_coef;
    end
    if (adv) begin
      rd_first_q <= mem_first[rd_first_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_ok && (s_axis_tuser == kc_pkg::OP_LOAD_SECOND)) begin
      mem_second[wr_addr] <= in_coef;
    end
    if (adv) begin
      rd_second_q <= mem_second[rd_second_addr];
    end
  end

  // ---------------------------------------------------------------
  // Term control pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
      s3_q <= '0;
    end else if (adv) begin
      s1_q <= (state_q == kc_pkg::ST_RUN) ? issue : '0;
      s2_q <= s1_q;
      s3_q <= s2_q;
    end
  end

  // Shared multiplier, or the copy value scaled to Q.32
  logic signed [PROD_W-1:0]    mul;
  logic signed [COEF_BITS-1:0] copy_val;
  logic signed [ACC_W-1:0]     prod_q, acc_q;

  assign mul      = rd_first_q * rd_second_q;
  assign copy_val = s1_q.src_second ? rd_second_q : rd_first_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (s1_q.copy) begin
        prod_q <= ACC_W'(copy_val) <<< kc_pkg::FRAC_BITS;
      end else if (s1_q.take) begin
        prod_q <= ACC_W'(mul);
      end else begin
        prod_q <= '0;
      end
    end
  end

  // Saturating accumulator
  always_ff @(posedge clk_i) begin
    if (adv && s2_q.valid) begin
      acc_q <= s2_q.first ? prod_q : sat_add(acc_q, prod_q);
    end
  end

  // Round half up to Q.16, clamp to coefficient range
  logic signed [ACC_W-1:0] rnd_sum, rnd_shf;
  logic                    rnd_fits;
  logic [COEF_BITS-1:0]    rnd_val;

  always_comb begin
    rnd_sum  = sat_add(acc_q, ROUND_HALF);
    rnd_shf  = rnd_sum >>> kc_pkg::FRAC_BITS;
    rnd_fits = (&rnd_shf[ACC_W-1:COEF_BITS-1]) || !(|rnd_shf[ACC_W-1:COEF_BITS-1]);
    if (rnd_fits) begin
      rnd_val = rnd_shf[COEF_BITS-1:0];
    end else if (rnd_shf[ACC_W-1]) begin
      rnd_val = {1'b1, {(COEF_BITS-1){1'b0}}};
    end else begin
      rnd_val = {1'b0, {(COEF_BITS-1){1'b1}}};
    end
  end

  // Output register
  logic                 m_valid_q, m_last_q, m_ovf_q;
  logic [COEF_BITS-1:0] m_coef_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= s3_q.valid && s3_q.last_term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_q.valid && s3_q.last_term) begin
      m_coef_q <= rnd_val;
      m_last_q <= s3_q.last_pos;
      m_ovf_q  <= !rnd_fits;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'(m_coef_q);
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_ovf_q;

  // ---------------------------------------------------------------
  // Assertions

  // input is only taken with an empty datapath
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (!s1_q.valid && !s2_q.valid && !s3_q.valid))
    else $error("input ready while terms in flight");

  // the sequencer only starts on an accepted word
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == kc_pkg::ST_RUN) |-> $past(in_acc))
    else $error("sequencer started without an input word");

  // after the last word goes out, no more terms are issued
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (state_q != kc_pkg::ST_RUN))
    else $error("issuing terms after the last word");

  // a stalled output freezes the accumulator
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(acc_q))
    else $error("accumulator moved during a stall");

endmodule
